// File: rtl/xpt_pkg.sv
// ----------------------------------------------------------------------------
// xpt_pkg
// Shared constants, register indexes and the popcount function for the
// XNOR-popcount threshold packing core.
// ----------------------------------------------------------------------------
`default_nettype none

package xpt_pkg;

  localparam int MAX_KERNEL_BITS_DEF = 4096;
  localparam int WORD_BITS           = 32;
  localparam int POS_W               = 5;
  localparam int THR_W               = 16;

  localparam int KB_REG_W  = 13;
  localparam int OC_REG_W  = 11;
  localparam int OFS_REG_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam logic [KB_REG_W-1:0]  KERNEL_BITS_RST      = 13'd32;
  localparam logic [OC_REG_W-1:0]  OUT_CHANNELS_RST     = 11'd32;
  localparam logic [OFS_REG_W-1:0] FIRST_OUT_OFFSET_RST = 5'd0;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BITS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_OUT_OFFSET = 2'd2;

  // One entry of the result queue.
  typedef struct packed {
    logic                 stream_select;
    logic [WORD_BITS-1:0] packed_word;
    logic                 run_end;
  } result_t;

  // Adder tree over the 32 bits, five levels deep.
  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/xnor_popcount_threshold_pack_core.sv
// ----------------------------------------------------------------------------
// xnor_popcount_threshold_pack_core
// Binary convolution engine for two time steps sharing one weight set:
// XNOR-popcount accumulation, signed thresholding and MSB-first bit packing.
// ----------------------------------------------------------------------------
// Each request carries one weight word and one activation word per time step.
// A request is registered on acceptance and processed once the result queue
// has room. The block takes one request per cycle unless it stalls. A request
// that closes a channel may produce up to two packed words (first time step
// before second), and the output delivers one word per cycle unless out_stall
// is high; a four-entry result queue absorbs this, and the input stalls while
// a held request finds fewer than two free queue entries. A write to one of
// the three configuration registers restarts the run: sums, word counter and
// both packers clear, and the packer positions reload from the registers.
`default_nettype none

module xnor_popcount_threshold_pack_core
  import xpt_pkg::*;
#(
  parameter int MAX_KERNEL_BITS = MAX_KERNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Configuration
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DAT_W-1:0]    cfg_data,
  // Input channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [WORD_BITS-1:0]    act_word_first,
  input  wire logic [WORD_BITS-1:0]    act_word_second,
  input  wire logic [WORD_BITS-1:0]    weight_word,
  input  wire logic signed [THR_W-1:0] threshold,
  input  wire logic                    final_channel,
  // Output channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         stream_select,
  output logic [WORD_BITS-1:0]         packed_word,
  output logic                         run_end
);

  localparam int SUM_W     = $clog2(MAX_KERNEL_BITS + 1);
  localparam int CMP_W     = (SUM_W + 1 > THR_W) ? SUM_W + 1 : THR_W;
  localparam int MAX_WORDS = (MAX_KERNEL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WC_W      = ($clog2(MAX_WORDS) > 0) ? $clog2(MAX_WORDS) : 1;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // Configuration registers
  logic [KB_REG_W-1:0]  kernel_bits, kernel_bits_next;
  logic [OC_REG_W-1:0]  out_channels, out_channels_next;
  logic [OFS_REG_W-1:0] first_out_offset, first_out_offset_next;
  logic                 cfg_hit;

  // Input register
  logic                    s_valid;
  logic [WORD_BITS-1:0]    s_act_first;
  logic [WORD_BITS-1:0]    s_act_second;
  logic [WORD_BITS-1:0]    s_weight;
  logic signed [THR_W-1:0] s_threshold;
  logic                    s_final;

  // Run state
  logic [SUM_W-1:0]     sum_first, sum_second;
  logic [WC_W-1:0]      word_count;
  logic [WORD_BITS-1:0] pack_first, pack_second;
  logic [POS_W-1:0]     pos_first, pos_second;

  // Result queue
  result_t              q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   q_wr_ptr, q_rd_ptr;
  logic [Q_CNT_W-1:0]   q_count;

  logic in_accept, proc, q_pop;

  // Datapath signals
  logic [31:0]              kb_eff;
  logic [WC_W:0]            words;
  logic [POS_W-1:0]         rem;
  logic                     last;
  logic [WORD_BITS-1:0]     mask;
  logic [SUM_W-1:0]         sum_first_new, sum_second_new;
  logic signed [CMP_W-1:0]  thr_ext, sum_first_ext, sum_second_ext;
  logic                     bit_first, bit_second;
  logic [WORD_BITS-1:0]     snap_first, snap_second;
  logic                     full_first, full_second;
  logic                     emit_first, emit_second;
  result_t                  res_first, res_second;

  // ---------------- configuration ----------------
  always_comb begin
    kernel_bits_next      = kernel_bits;
    out_channels_next     = out_channels;
    first_out_offset_next = first_out_offset;
    cfg_hit               = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_KERNEL_BITS: begin
          kernel_bits_next = cfg_data[KB_REG_W-1:0];
          cfg_hit          = 1'b1;
        end
        REG_OUT_CHANNELS: begin
          out_channels_next = cfg_data[OC_REG_W-1:0];
          cfg_hit           = 1'b1;
        end
        REG_FIRST_OUT_OFFSET: begin
          first_out_offset_next = cfg_data[OFS_REG_W-1:0];
          cfg_hit               = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_bits      <= KERNEL_BITS_RST;
      out_channels     <= OUT_CHANNELS_RST;
      first_out_offset <= FIRST_OUT_OFFSET_RST;
    end else begin
      kernel_bits      <= kernel_bits_next;
      out_channels     <= out_channels_next;
      first_out_offset <= first_out_offset_next;
    end
  end

  // ---------------- handshake ----------------
  assign proc      = s_valid && (q_count <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_stall  = s_valid && !proc;
  assign in_accept = in_valid && !in_stall;
  assign q_pop     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_accept) begin
      s_valid <= 1'b1;
    end else if (proc) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_act_first  <= act_word_first;
      s_act_second <= act_word_second;
      s_weight     <= weight_word;
      s_threshold  <= threshold;
      s_final      <= final_channel;
    end
  end

  // ---------------- datapath ----------------
  always_comb begin
    if (kernel_bits == '0) begin
      kb_eff = 32'd1;
    end else if (32'(kernel_bits) > 32'(MAX_KERNEL_BITS)) begin
      kb_eff = 32'(MAX_KERNEL_BITS);
    end else begin
      kb_eff = 32'(kernel_bits);
    end
    words = (WC_W + 1)'((kb_eff + 32'd31) >> 5);
    rem   = kb_eff[POS_W-1:0];
    last  = (({1'b0, word_count} + (WC_W + 1)'(1)) >= words);

    // The closing word of a channel counts only its top bits.
    if (last && (rem != '0)) begin
      mask = ~({WORD_BITS{1'b1}} >> rem);
    end else begin
      mask = {WORD_BITS{1'b1}};
    end

    sum_first_new  = sum_first +
                     SUM_W'(popcount32(~(s_act_first ^ s_weight) & mask));
    sum_second_new = sum_second +
                     SUM_W'(popcount32(~(s_act_second ^ s_weight) & mask));

    thr_ext        = CMP_W'(s_threshold);
    sum_first_ext  = $signed({{(CMP_W - SUM_W){1'b0}}, sum_first_new});
    sum_second_ext = $signed({{(CMP_W - SUM_W){1'b0}}, sum_second_new});
    bit_first      = (sum_first_ext >= thr_ext);
    bit_second     = (sum_second_ext >= thr_ext);

    snap_first  = pack_first | (WORD_BITS'(bit_first) << (5'd31 - pos_first));
    snap_second = pack_second | (WORD_BITS'(bit_second) << (5'd31 - pos_second));
    full_first  = (pos_first == 5'd31);
    full_second = (pos_second == 5'd31);
    emit_first  = last && (full_first || (s_final && (snap_first != '0)));
    emit_second = last && (full_second || (s_final && (snap_second != '0)));

    res_first.stream_select  = 1'b0;
    res_first.packed_word    = snap_first;
    res_first.run_end        = !emit_second;
    res_second.stream_select = 1'b1;
    res_second.packed_word   = snap_second;
    res_second.run_end       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_first   <= '0;
      sum_second  <= '0;
      word_count  <= '0;
      pack_first  <= '0;
      pack_second <= '0;
      pos_first   <= FIRST_OUT_OFFSET_RST;
      pos_second  <= FIRST_OUT_OFFSET_RST + OUT_CHANNELS_RST[POS_W-1:0];
    end else if (cfg_hit) begin
      sum_first   <= '0;
      sum_second  <= '0;
      word_count  <= '0;
      pack_first  <= '0;
      pack_second <= '0;
      pos_first   <= first_out_offset_next;
      pos_second  <= first_out_offset_next + out_channels_next[POS_W-1:0];
    end else if (proc) begin
      if (!last) begin
        sum_first  <= sum_first_new;
        sum_second <= sum_second_new;
        word_count <= word_count + WC_W'(1);
      end else begin
        sum_first  <= '0;
        sum_second <= '0;
        word_count <= '0;
        if (s_final) begin
          // End of run: both packers start over from the registers.
          pack_first  <= '0;
          pack_second <= '0;
          pos_first   <= first_out_offset;
          pos_second  <= first_out_offset + out_channels[POS_W-1:0];
        end else begin
          pack_first  <= full_first ? '0 : snap_first;
          pack_second <= full_second ? '0 : snap_second;
          pos_first   <= pos_first + 5'd1;
          pos_second  <= pos_second + 5'd1;
        end
      end
    end
  end

  // ---------------- result queue ----------------
  logic [1:0] q_push_cnt;

  always_comb begin
    q_push_cnt = '0;
    if (proc) begin
      q_push_cnt = {1'b0, emit_first} + {1'b0, emit_second};
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      if (emit_first) begin
        q_mem[q_wr_ptr] <= res_first;
        if (emit_second) begin
          q_mem[q_wr_ptr + Q_PTR_W'(1)] <= res_second;
        end
      end else if (emit_second) begin
        q_mem[q_wr_ptr] <= res_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      q_wr_ptr <= q_wr_ptr + Q_PTR_W'(q_push_cnt);
      if (q_pop) begin
        q_rd_ptr <= q_rd_ptr + Q_PTR_W'(1);
      end
      q_count <= q_count + Q_CNT_W'(q_push_cnt) - Q_CNT_W'(q_pop);
    end
  end

  assign out_valid     = (q_count != '0);
  assign stream_select = q_mem[q_rd_ptr].stream_select;
  assign packed_word   = q_mem[q_rd_ptr].packed_word;
  assign run_end       = q_mem[q_rd_ptr].run_end;

endmodule

`default_nettype wire
